>>> src/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/fstg_pkg.sv
// package with widths, constants and codes of the faded square tone generator
package fstg_pkg;

  localparam int CNT_W     = 22;
  localparam int RATE_W    = 16;
  localparam int VOL_W     = 7;
  localparam int FREQ_W    = 15;
  localparam int MS_W      = 16;
  localparam int SMP_W     = 15;
  localparam int EDGE_W    = 8;
  localparam int AMP_W     = 14;
  localparam int FADE_W    = AMP_W + EDGE_W;
  localparam int DIV_W     = RATE_W + MS_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 1;

  localparam int AMP_PEAK  = 12000;
  localparam int PCT_FULL  = 100;
  localparam int AMP_STEP  = AMP_PEAK / PCT_FULL;
  localparam int MS_PER_S  = 1000;
  localparam int EDGE_DIV  = 200;

  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(16000);
  localparam logic [VOL_W-1:0]  VOL_RST  = VOL_W'(PCT_FULL);
  localparam logic [VOL_W-1:0]  VOL_MAX  = VOL_W'(PCT_FULL);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 1'b0,
    REG_VOLUME_PCT  = 1'b1
  } reg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TOT      = 7'b0000010,
    S_EDGE     = 7'b0000100,
    S_STEP     = 7'b0001000,
    S_FADE_IN  = 7'b0010000,
    S_FADE_OUT = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

endpackage

>>> src/faded_square_tone_generator_core.sv
// top level of the faded square tone generator with its serial divider
// Faded square tone generator.
// Input channel (in_valid/in_ready): a word with in_start_req high loads a note
// from in_tone_freq and in_duration_ms and gives no sample; a word with
// in_start_req low is a tick that gives one sample while a note plays, and
// nothing otherwise. Output channel (out_valid/out_ready): out_sample, a signed
// square wave with a linear fade at both ends, and out_last on the final
// sample of the note. Config channel (cfg_valid/cfg_ready, always ready):
// cfg_index 0 writes the sample rate, 1 the volume percent, from cfg_data.
// All scaling runs through one restoring divider that retires one quotient bit
// per cycle. A start word, once accepted, runs three divisions in turn, of 32,
// 16 and 15 bits. A tick runs no division without fade, one 22-bit division in
// one fade ramp and two 22-bit divisions where both ramps overlap.
// Results sit in an output register; a new word is taken while it waits, and a
// tick only stalls in its final cycle until that register is free.
// Reset (rst_n low at a clock edge) goes idle with no note playing, sample rate
// 16000 and volume 100.
module faded_square_tone_generator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_req,
  input  logic [fstg_pkg::FREQ_W-1:0]  in_tone_freq,
  input  logic [fstg_pkg::MS_W-1:0]    in_duration_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [fstg_pkg::SMP_W-1:0] out_sample,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fstg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fstg_pkg::RATE_W-1:0]  cfg_data
);
  import fstg_pkg::*;
  `include "assert_macros.svh"

  state_t                state_r, state_nxt;
  logic [RATE_W-1:0]     rate_r, rate_nxt;
  logic [VOL_W-1:0]      vol_r, vol_nxt;
  logic                  active_r, active_nxt;
  logic                  note_ok_r, note_ok_nxt;
  logic [CNT_W-1:0]      index_r, index_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [RATE_W-1:0]     phase_r, phase_nxt;
  logic [RATE_W-1:0]     step_r, step_nxt;
  logic [EDGE_W-1:0]     edge_r, edge_nxt;
  logic [AMP_W-1:0]      amp_r, amp_nxt;
  logic [FREQ_W-1:0]     freq_r, freq_nxt;
  logic [AMP_W-1:0]      mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_W-1:0]      quo_r, quo_nxt;
  logic [RATE_W-1:0]     rem_r, rem_nxt;
  logic [RATE_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SMP_W-1:0] out_sample_r, out_sample_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [RATE_W:0]       trial;
  logic [RATE_W:0]       diff;
  logic                  ge;
  logic                  div_busy;
  logic                  in_acc;
  logic [VOL_W-1:0]      vol_c;
  logic                  fade_out_c;
  logic [EDGE_W-1:0]     gap_c;
  logic [FADE_W-1:0]     fade_in_prod;
  logic [FADE_W-1:0]     fade_out_prod;
  logic [FADE_W-1:0]     fade_out2_prod;
  logic [RATE_W:0]       phase_sum;
  logic [SMP_W-1:0]      mag_ext;
  logic                  fin_c;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  assign in_acc   = in_valid && in_ready;
  assign div_busy = (cnt_r != '0);
  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});

  assign vol_c      = (vol_r > VOL_MAX) ? VOL_MAX : vol_r;
  assign gap_c      = EDGE_W'(total_r - index_r);
  assign fade_out_c = (edge_r != '0) &&
                      (({1'b0, index_r} + (CNT_W + 1)'(edge_r)) > {1'b0, total_r});
  assign fade_in_prod   = FADE_W'(amp_r) * FADE_W'(index_r[EDGE_W-1:0]);
  assign fade_out_prod  = FADE_W'(amp_r) * FADE_W'(gap_c);
  assign fade_out2_prod = FADE_W'(quo_r[AMP_W-1:0]) * FADE_W'(gap_c);
  assign phase_sum  = {1'b0, phase_r} + {1'b0, step_r};
  assign mag_ext    = {1'b0, mag_r};
  assign fin_c      = (({1'b0, index_r} + (CNT_W + 1)'(1)) >= {1'b0, total_r});

  always_comb begin
    state_nxt      = state_r;
    rate_nxt       = rate_r;
    vol_nxt        = vol_r;
    active_nxt     = active_r;
    note_ok_nxt    = note_ok_r;
    index_nxt      = index_r;
    total_nxt      = total_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    edge_nxt       = edge_r;
    amp_nxt        = amp_r;
    freq_nxt       = freq_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;

    if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_SAMPLE_RATE: rate_nxt = cfg_data;
        REG_VOLUME_PCT:  vol_nxt  = cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end

    if (div_busy) begin
      rem_nxt = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_start_req) begin
            active_nxt  = 1'b0;
            index_nxt   = '0;
            phase_nxt   = '0;
            freq_nxt    = in_tone_freq;
            amp_nxt     = AMP_W'(vol_c) * AMP_W'(AMP_STEP);
            note_ok_nxt = (in_tone_freq != '0) && (in_duration_ms != '0) && (vol_c != '0);
            quo_nxt     = DIV_W'(rate_r) * DIV_W'(in_duration_ms);
            rem_nxt     = '0;
            dvs_nxt     = RATE_W'(MS_PER_S);
            cnt_nxt     = DIV_CNT_W'(DIV_W);
            state_nxt   = S_TOT;
          end else if (active_r) begin
            neg_nxt = !({1'b0, phase_r, 1'b0} < {2'b00, rate_r});
            mag_nxt = amp_r;
            rem_nxt = '0;
            dvs_nxt = RATE_W'(edge_r);
            if ((edge_r != '0) && (index_r < CNT_W'(edge_r))) begin
              quo_nxt   = DIV_W'(fade_in_prod) << (DIV_W - FADE_W);
              cnt_nxt   = DIV_CNT_W'(FADE_W);
              state_nxt = S_FADE_IN;
            end else if (fade_out_c) begin
              quo_nxt   = DIV_W'(fade_out_prod) << (DIV_W - FADE_W);
              cnt_nxt   = DIV_CNT_W'(FADE_W);
              state_nxt = S_FADE_OUT;
            end else begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_TOT: begin
        if (!div_busy) begin
          total_nxt = (|quo_r[DIV_W-1:CNT_W]) ? CNT_MAX : quo_r[CNT_W-1:0];
          quo_nxt   = {rate_r, {(DIV_W-RATE_W){1'b0}}};
          rem_nxt   = '0;
          dvs_nxt   = RATE_W'(EDGE_DIV);
          cnt_nxt   = DIV_CNT_W'(RATE_W);
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (!div_busy) begin
          edge_nxt  = (|quo_r[DIV_W-1:EDGE_W]) ? EDGE_MAX : quo_r[EDGE_W-1:0];
          quo_nxt   = {freq_r, {(DIV_W-FREQ_W){1'b0}}};
          rem_nxt   = '0;
          dvs_nxt   = rate_r;
          cnt_nxt   = DIV_CNT_W'(FREQ_W);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (!div_busy) begin
          step_nxt   = (rate_r == '0) ? '0 : rem_r;
          active_nxt = note_ok_r && (total_r != '0);
          state_nxt  = S_IDLE;
        end
      end
      S_FADE_IN: begin
        if (!div_busy) begin
          mag_nxt = quo_r[AMP_W-1:0];
          if (fade_out_c) begin
            quo_nxt   = DIV_W'(fade_out2_prod) << (DIV_W - FADE_W);
            rem_nxt   = '0;
            cnt_nxt   = DIV_CNT_W'(FADE_W);
            state_nxt = S_FADE_OUT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_FADE_OUT: begin
        if (!div_busy) begin
          mag_nxt   = quo_r[AMP_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = neg_r ? -mag_ext : mag_ext;
          out_last_nxt   = fin_c;
          phase_nxt      = (phase_sum >= {1'b0, rate_r}) ?
                           RATE_W'(phase_sum - {1'b0, rate_r}) : phase_sum[RATE_W-1:0];
          index_nxt      = index_r + CNT_W'(1);
          if (fin_c) begin
            active_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= RATE_RST;
      vol_r       <= VOL_RST;
      active_r    <= 1'b0;
      note_ok_r   <= 1'b0;
      index_r     <= '0;
      total_r     <= '0;
      phase_r     <= '0;
      step_r      <= '0;
      edge_r      <= '0;
      amp_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      vol_r       <= vol_nxt;
      active_r    <= active_nxt;
      note_ok_r   <= note_ok_nxt;
      index_r     <= index_nxt;
      total_r     <= total_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      edge_r      <= edge_nxt;
      amp_r       <= amp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r       <= freq_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  `ASSERT_NEXT(a_out_from_commit, (state_r != S_OUT) && !out_valid_r, !out_valid_r, "stray word")
  `ASSERT_IMPL(a_index_in_note, active_r, index_r < total_r, "sample index ran past the note")
  `ASSERT_IMPL(a_fade_edge, (state_r == S_FADE_IN) || (state_r == S_FADE_OUT), edge_r != '0, "zero edge")

endmodule

>>> sim/testbench.sv
// self-checking testbench of the faded square tone generator core with a predicting scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fstg_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned NUM_SETTINGS = 14;
  localparam int unsigned WORDS_PER_SETTING = 95;

  typedef struct packed {
    logic signed [SMP_W-1:0] pcm;
    logic                    last;
  } tone_sample_t;

  class tone_scoreboard;
    logic [RATE_W-1:0] rate;
    logic [VOL_W-1:0]  volume;
    logic              playing;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  total;
    logic [RATE_W-1:0] phase_rem;
    logic [RATE_W-1:0] phase_inc;
    logic [EDGE_W-1:0] ramp_len;
    logic [AMP_W-1:0]  amp;
    tone_sample_t      expected_samples[$];
    int unsigned       notes_loaded;
    int unsigned       samples_checked;
    int unsigned       mismatches;

    function new();
      rate = RATE_RST;
      volume = VOL_RST;
      playing = 1'b0;
      pos = '0;
      total = '0;
      phase_rem = '0;
      phase_inc = '0;
      ramp_len = '0;
      amp = '0;
      notes_loaded = 0;
      samples_checked = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [RATE_W-1:0] data);
      if (idx == REG_SAMPLE_RATE) begin
        rate = data;
      end else begin
        volume = data[VOL_W-1:0];
      end
    endfunction

    function void load_note(logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
      longint unsigned span;
      int unsigned vol;
      int unsigned ramp;
      vol = (volume > VOL_MAX) ? PCT_FULL : volume;
      span = 64'(rate) * 64'(ms) / MS_PER_S;
      if (span > CNT_MAX) span = CNT_MAX;
      total = CNT_W'(span);
      ramp = rate / EDGE_DIV;
      ramp_len = (ramp > EDGE_MAX) ? EDGE_MAX : EDGE_W'(ramp);
      amp = AMP_W'(AMP_PEAK * vol / PCT_FULL);
      phase_inc = (rate != 0) ? RATE_W'(freq % rate) : '0;
      pos = '0;
      phase_rem = '0;
      playing = (freq != 0 && ms != 0 && vol != 0 && total != 0);
      notes_loaded++;
    endfunction

    // accepted input word: a start loads a note, a tick may give one sample
    function void note_word(logic start, logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
      tone_sample_t s;
      longint unsigned mag;
      logic [RATE_W:0] next;
      logic neg;
      logic fin;
      if (start) begin
        load_note(freq, ms);
        return;
      end
      if (!playing) return;
      neg = !({phase_rem, 1'b0} < {1'b0, rate});
      mag = amp;
      if (ramp_len != 0) begin
        if (pos < ramp_len) mag = mag * pos / ramp_len;
        if (64'(pos) + ramp_len > total) mag = mag * (total - pos) / ramp_len;
      end
      fin = (64'(pos) + 1 >= total);
      s.pcm = SMP_W'(neg ? -mag : mag);
      s.last = fin;
      expected_samples.push_back(s);
      next = phase_rem + phase_inc;
      if (next >= rate) next = next - rate;
      phase_rem = next[RATE_W-1:0];
      pos = pos + 1'b1;
      if (fin) playing = 1'b0;
    endfunction

    function void check_sample(logic signed [SMP_W-1:0] pcm, logic last);
      tone_sample_t want;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample %0d last %0b with nothing pending", pcm, last);
        return;
      end
      want = expected_samples.pop_front();
      samples_checked++;
      if (want.pcm !== pcm || want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                   want.pcm, want.last, pcm, last);
      end
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_start_req = 1'b0;
  logic [FREQ_W-1:0] in_tone_freq = '0;
  logic [MS_W-1:0] in_duration_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_sample;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_SAMPLE_RATE;
  logic [RATE_W-1:0] cfg_data = '0;

  tone_scoreboard scoreboard = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned rate_list[NUM_SETTINGS] = '{8000, 48000, 150, 65535, 44100, 0, 22050,
                                           200, 11025, 16000, 1, 16000, 32768, 16000};
  int unsigned vol_list[NUM_SETTINGS] = '{100, 127, 60, 100, 0, 100, 1,
                                          100, 75, 100, 100, 100, 50, 100};

  faded_square_tone_generator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_tone_freq   (in_tone_freq),
    .in_duration_ms (in_duration_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample     (out_sample),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // results are checked before the word of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) scoreboard.check_sample(out_sample, out_last);
      if (in_valid && in_ready) scoreboard.note_word(in_start_req, in_tone_freq, in_duration_ms);
      if (cfg_valid && cfg_ready) scoreboard.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_word(input logic start, input logic [FREQ_W-1:0] freq,
                           input logic [MS_W-1:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_tone_freq <= freq;
    in_duration_ms <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(1'b0, FREQ_W'($urandom), MS_W'($urandom));
  endtask

  task automatic play_note(input logic [FREQ_W-1:0] freq, input logic [MS_W-1:0] ms,
                           input int unsigned ticks);
    send_word(1'b1, freq, ms);
    repeat (ticks) send_tick();
  endtask

  // duration that gives at least the wanted sample count at the current rate, up to the 16-bit duration limit
  function automatic logic [MS_W-1:0] ms_for(int unsigned samples);
    longint unsigned m;
    if (scoreboard.rate == 0) return MS_W'($urandom_range(1, 65535));
    m = (64'(samples) * MS_PER_S + scoreboard.rate - 1) / scoreboard.rate;
    if (m == 0) m = 1;
    if (m > 65535) m = 65535;
    return MS_W'(m);
  endfunction

  task automatic random_note();
    int unsigned pick;
    int unsigned want;
    int unsigned ticks;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0] ms;
    pick = $urandom_range(99);
    want = ($urandom_range(9) == 0) ? $urandom_range(60, 700) : $urandom_range(1, 60);
    freq = ($urandom_range(4) == 0) ? FREQ_W'($urandom) : FREQ_W'($urandom_range(1, 20000));
    ms = ms_for(want);
    ticks = want + $urandom_range(0, 2);
    if (pick < 8) begin
      ms = MS_W'($urandom);
      ticks = $urandom_range(0, 20);
    end else if (pick < 12) begin
      freq = '0;
    end else if (pick < 16) begin
      ms = '0;
    end else if (pick < 30) begin
      ticks = $urandom_range(0, want);
    end
    play_note(freq, ms, ticks);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned rate, input int unsigned vol);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_data <= RATE_W'(rate);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_VOLUME_PCT;
    cfg_data <= {9'($urandom), VOL_W'(vol)};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    rate_list[9] = $urandom_range(8000, 48000);
    rate_list[13] = $urandom_range(0, 65535);
    vol_list[9] = $urandom_range(0, 127);
    vol_list[13] = $urandom_range(0, 127);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero duration then a tick while idle, a rest, top fields, restart mid note
    play_note(FREQ_W'(1000), MS_W'(0), 1);
    play_note(FREQ_W'(0), MS_W'(5), 0);
    play_note('1, '1, 2);
    play_note(FREQ_W'(440), MS_W'(1), 16);
    play_note(FREQ_W'(3000), MS_W'(50), 3);
    settle();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      configure(rate_list[p], vol_list[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 84;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      // the carried note keeps playing under the new rate
      repeat ($urandom_range(1, 6)) send_tick();
      play_note(FREQ_W'($urandom_range(1, 20000)), '1, $urandom_range(1, 4));
      goal = words_sent + WORDS_PER_SETTING;
      while (words_sent < goal)
        random_note();
      play_note(FREQ_W'($urandom_range(1, 20000)), ms_for(400), 2);
      settle();
    end

    $display("covered %0d words, %0d notes and %0d checked samples over %0d settings",
             words_sent, scoreboard.notes_loaded, scoreboard.samples_checked,
             NUM_SETTINGS + 1);
    $display("sender gaps and receiver stalls taken in turn, %0d mismatches",
             scoreboard.mismatches);
    if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
      $display("PASS faded_square_tone_generator_core");
    end else begin
      $display("FAIL faded_square_tone_generator_core");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d samples still pending", scoreboard.pending());
    $display("FAIL faded_square_tone_generator_core");
    $finish;
  end

endmodule
